FILE: rtl/core/srf_pkg.sv
// shared types and constants of the substring removal filter
// no dependencies
`default_nettype none

package srf_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 4;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = CFG_INDEX_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHRINK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
        logic              out_last;
        logic              none_removed;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/srf_in_if.sv
// input byte channel of the substring removal filter
// depends on srf_pkg
`default_nettype none

interface srf_in_if import srf_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/srf_out_if.sv
// result channel of the substring removal filter
// depends on srf_pkg
`default_nettype none

interface srf_out_if import srf_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic              out_last;
    logic              none_removed;

    modport source (output valid, output out_byte, output out_valid, output out_last,
                    output none_removed, input ready);
    modport sink (input valid, input out_byte, input out_valid, input out_last,
                  input none_removed, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/srf_cfg_if.sv
// register write channel of the substring removal filter
// depends on srf_pkg
`default_nettype none

interface srf_cfg_if import srf_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/srf_cell.sv
// one window cell: holds a byte, takes a new byte or its neighbor's byte
// depends on srf_pkg
`default_nettype none

module srf_cell
    import srf_pkg::*;
(
    input  wire logic              clk,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [BYTE_W-1:0] new_byte,
    input  wire logic [BYTE_W-1:0] right_view,
    input  wire logic [BYTE_W-1:0] pat_byte,
    output logic      [BYTE_W-1:0] view,
    output logic                   eq
);

    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;

    assign view      = ctrl.load ? new_byte : data_reg;
    assign eq        = (view == pat_byte);
    assign data_next = ctrl.shift ? right_view : view;

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/srf_out_fifo.sv
// two-entry result queue between the window chain and the result channel
// depends on srf_pkg and srf_out_if
`default_nettype none

module srf_out_fifo
    import srf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         space,
    srf_out_if.source    result
);

    result_t    mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign space               = (count_reg != 2'd2);
    assign pop                 = result.valid && result.ready;
    assign result.valid        = (count_reg != 2'd0);
    assign result.out_byte     = mem[rd_ptr_reg].out_byte;
    assign result.out_valid    = mem[rd_ptr_reg].out_valid;
    assign result.out_last     = mem[rd_ptr_reg].out_last;
    assign result.none_removed = mem[rd_ptr_reg].none_removed;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/substring_removal_filter.sv
// top level: removes every occurrence of a pattern from a byte stream
// depends on srf_pkg, srf_in_if, srf_out_if, srf_cfg_if, srf_cell, srf_out_fifo
// one item per cycle with queue space if it yields at most one result; a push shows next cycle
// at end of string the flush sequencer drains each held window byte (up to MAX_PATTERN)
// after a mid-string shortening of the pattern, surplus window bytes drain first (ST_SHRINK)
// the two-entry result queue lets items keep entering while a result waits
// reset clears control state, pattern to zero and length to one; no clearing pass
`default_nettype none

module substring_removal_filter
    import srf_pkg::*;
#(
    parameter int MAX_PATTERN = 8
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    srf_in_if.sink    feed,
    srf_out_if.source result,
    srf_cfg_if.sink   cfg
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PATTERN);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

    logic [CFG_DATA_W-1:0] pattern_reg;
    logic [LEN_W-1:0]      length_reg;
    state_t                state_reg;
    state_t                state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  removed_reg;
    logic                  removed_next;
    logic [BYTE_W-1:0]     held_byte_reg;
    logic                  held_last_reg;
    logic [BYTE_W-1:0]     pend_byte_reg;

    logic [CNT_W-1:0]      len_eff;
    logic                  over_len;
    logic                  push_ok;
    logic                  accept;
    logic [BYTE_W-1:0]     cur_byte;
    logic                  cur_last;
    logic                  append_go;
    logic                  drain_go;
    logic                  pend_hold;
    logic [CNT_W-1:0]      cnt_app;
    logic                  full_app;
    logic                  match_all;
    logic                  hit;
    logic                  emit_app;
    logic [CNT_W-1:0]      cnt_after;
    logic                  push;
    result_t               push_data;

    cell_ctrl_t            ctrl [MAX_PATTERN];
    logic [BYTE_W-1:0]     views [MAX_PATTERN + 1];
    logic [MAX_PATTERN-1:0] eq_vec;
    logic [MAX_PATTERN-1:0] match_vec;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= LEN_W'(1);
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_PATTERN_BYTES:  pattern_reg <= cfg.data;
                CFG_PATTERN_LENGTH: length_reg  <= cfg.data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        if (length_reg == '0)
            len_eff = CNT_W'(1);
        else if (length_reg > LEN_MAX)
            len_eff = CNT_MAX;
        else
            len_eff = length_reg[CNT_W-1:0];
    end

    assign over_len   = (count_reg >= len_eff);
    assign feed.ready = (state_reg == ST_IDLE) && push_ok;
    assign accept     = feed.valid && feed.ready;
    assign cur_byte   = (state_reg == ST_IDLE) ? feed.in_byte : held_byte_reg;
    assign cur_last   = (state_reg == ST_IDLE) ? feed.in_last : held_last_reg;

    assign append_go = push_ok && !over_len
                       && ((state_reg == ST_IDLE && accept) || state_reg == ST_SHRINK);
    assign drain_go  = push_ok
                       && ((state_reg == ST_SHRINK && over_len) || state_reg == ST_FLUSH);

    // last surplus byte of a final item waits until the append decides the end mark
    assign pend_hold = drain_go && (state_reg == ST_SHRINK) && held_last_reg
                       && (count_reg == len_eff);

    assign cnt_app   = count_reg + CNT_W'(1);
    assign full_app  = (cnt_app == len_eff);
    assign match_all = &match_vec;
    assign hit       = append_go && full_app && match_all;
    assign emit_app  = append_go && full_app && !match_all && !cur_last;

    // window chain, cell 0 is the oldest byte
    assign views[MAX_PATTERN] = '0;

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        assign ctrl[i].load  = append_go && (count_reg == CNT_W'(i));
        assign ctrl[i].shift = drain_go || emit_app;
        assign match_vec[i]  = eq_vec[i] || (CNT_W'(i) >= len_eff);

        srf_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl[i]),
            .new_byte   (cur_byte),
            .right_view (views[i + 1]),
            .pat_byte   (pattern_reg[BYTE_W*i +: BYTE_W]),
            .view       (views[i]),
            .eq         (eq_vec[i])
        );
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        removed_next = removed_reg;
        push         = 1'b0;
        push_data    = '0;
        cnt_after    = cnt_app;

        if (hit)
            cnt_after = '0;
        else if (emit_app)
            cnt_after = count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && over_len)
                    state_next = ST_SHRINK;
            end
            ST_SHRINK:
            begin
            end
            ST_FLUSH:
            begin
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (append_go)
        begin
            count_next = cnt_after;
            if (hit)
                removed_next = 1'b1;
            if (emit_app)
            begin
                push                = 1'b1;
                push_data.out_byte  = views[0];
                push_data.out_valid = 1'b1;
            end
            if (state_reg == ST_SHRINK && cur_last)
            begin
                push                = 1'b1;
                push_data.out_byte  = pend_byte_reg;
                push_data.out_valid = 1'b1;
            end
            if (cur_last)
            begin
                if (cnt_after == '0)
                begin
                    // occurrence ended the string: end mark on the last result
                    push                   = 1'b1;
                    push_data.out_last     = 1'b1;
                    push_data.none_removed = !(removed_reg || hit);
                    removed_next           = 1'b0;
                    state_next             = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            else
            begin
                state_next = ST_IDLE;
            end
        end

        if (drain_go)
        begin
            push                = !pend_hold;
            push_data.out_byte  = views[0];
            push_data.out_valid = 1'b1;
            count_next          = count_reg - CNT_W'(1);
            if (state_reg == ST_FLUSH && count_reg == CNT_W'(1))
            begin
                push_data.out_last     = 1'b1;
                push_data.none_removed = !removed_reg;
                removed_next           = 1'b0;
                state_next             = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            removed_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            removed_reg <= removed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_byte_reg <= feed.in_byte;
            held_last_reg <= feed.in_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_hold)
        begin
            pend_byte_reg <= views[0];
        end
    end

    srf_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .space     (push_ok),
        .result    (result)
    );

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("window count above maximum");

    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FLUSH |-> count_reg != '0)
        else $error("flush with empty window");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.out_last) |=> (!removed_reg && count_reg == '0))
        else $error("string state not cleared after final item");

    a_shrink_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && over_len) |=> (state_reg == ST_SHRINK))
        else $error("surplus window not drained before append");
`endif

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of substring_removal_filter: directed strings first, then random ones
// predicts the filtered bytes of every accepted item and checks each result field in order
// depends on srf_pkg, srf_in_if, srf_out_if, srf_cfg_if and the filter rtl

module testbench;
    import srf_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int MAX_PATTERN   = 8;
    localparam int RANDOM_ITEMS  = 330;
    localparam int SETTLE_CYCLES = 2 * MAX_PATTERN + 4;
    localparam int IDLE_BOUND    = 100000;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = CFG_INDEX_W'(15);

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } feed_item_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    srf_in_if  feed_if ();
    srf_out_if result_if ();
    srf_cfg_if cfg_if ();

    substring_removal_filter #(.MAX_PATTERN(MAX_PATTERN)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    // items waiting for the driver and results waiting for the filter
    feed_item_t byte_queue[$];
    result_t    awaited_results[$];
    int         queued_items   = 0;
    int         accepted_items = 0;
    int         errors         = 0;

    // predictor copy of registers and window
    logic [CFG_DATA_W-1:0] pat_reg = '0;
    logic [LEN_W-1:0]      len_reg = LEN_W'(1);
    logic [BYTE_W-1:0]     win_bytes [MAX_PATTERN] = '{default: '0};
    int                    win_fill   = 0;
    bit                    string_hit = 1'b0;

    // settings as last written by the stimulus
    logic [CFG_DATA_W-1:0] gen_pattern = '0;
    logic [LEN_W-1:0]      gen_length  = LEN_W'(1);

    feed_item_t  next_item;
    int          burst_left  = 0;
    int          gap_left    = 0;
    logic [15:0] stall_mask  = 16'hFFFF;
    int          stall_phase = 0;

    always #CLK_HALF clk = ~clk;

    function automatic int clamp_length(input logic [LEN_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_PATTERN)
            return MAX_PATTERN;
        return int'(raw);
    endfunction

    task automatic shift_out_oldest(ref result_t produced[$]);
        result_t r;
        int      i;
        r.out_byte     = win_bytes[0];
        r.out_valid    = 1'b1;
        r.out_last     = 1'b0;
        r.none_removed = 1'b0;
        produced.push_back(r);
        for (i = 1; i < MAX_PATTERN; i++)
            win_bytes[i-1] = win_bytes[i];
        win_bytes[MAX_PATTERN-1] = '0;
        win_fill--;
    endtask

    task automatic filter_byte(input logic [BYTE_W-1:0] b, input logic last);
        result_t produced[$];
        result_t r;
        int      len;
        int      i;
        bit      hit;
        len = clamp_length(len_reg);
        // a shorter pattern pushes surplus window bytes out first
        while (win_fill > len - 1)
            shift_out_oldest(produced);
        win_bytes[win_fill] = b;
        win_fill++;
        if (win_fill == len) begin
            hit = 1'b1;
            for (i = 0; i < len; i++)
                if (win_bytes[i] != pat_reg[8*i +: 8])
                    hit = 1'b0;
            if (hit) begin
                win_bytes  = '{default: '0};
                win_fill   = 0;
                string_hit = 1'b1;
            end else if (!last) begin
                shift_out_oldest(produced);
            end
        end
        if (last) begin
            while (win_fill > 0)
                shift_out_oldest(produced);
            if (produced.size() == 0) begin
                r.out_byte     = '0;
                r.out_valid    = 1'b0;
                r.out_last     = 1'b0;
                r.none_removed = 1'b0;
                produced.push_back(r);
            end
            r              = produced.pop_back();
            r.out_last     = 1'b1;
            r.none_removed = !string_hit;
            produced.push_back(r);
            win_bytes  = '{default: '0};
            win_fill   = 0;
            string_hit = 1'b0;
        end
        foreach (produced[k])
            awaited_results.push_back(produced[k]);
    endtask

    task automatic check_result();
        result_t want;
        if (awaited_results.size() == 0) begin
            $error("result with no item behind it: out_byte %0h", result_if.out_byte);
            errors++;
        end else begin
            want = awaited_results.pop_front();
            if (result_if.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0h, got %0h", want.out_byte, result_if.out_byte);
                errors++;
            end
            if (result_if.out_valid !== want.out_valid) begin
                $error("out_valid: expected %0b, got %0b", want.out_valid, result_if.out_valid);
                errors++;
            end
            if (result_if.out_last !== want.out_last) begin
                $error("out_last: expected %0b, got %0b", want.out_last, result_if.out_last);
                errors++;
            end
            if (result_if.none_removed !== want.none_removed) begin
                $error("none_removed: expected %0b, got %0b",
                       want.none_removed, result_if.none_removed);
                errors++;
            end
        end
    endtask

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                if (cfg_if.index == CFG_PATTERN_BYTES)
                    pat_reg = cfg_if.data;
                else if (cfg_if.index == CFG_PATTERN_LENGTH)
                    len_reg = cfg_if.data[LEN_W-1:0];
            end
            if (feed_if.valid && feed_if.ready)
            begin
                filter_byte(feed_if.in_byte, feed_if.in_last);
                accepted_items++;
            end
            if (result_if.valid && result_if.ready)
                check_result();
        end
    end

    // driver: bursts of items with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            feed_if.valid <= 1'b0;
        else if (!feed_if.valid || feed_if.ready)
        begin
            if (gap_left > 0 || byte_queue.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                feed_if.valid <= 1'b0;
            end
            else
            begin
                next_item = byte_queue.pop_front();
                feed_if.valid   <= 1'b1;
                feed_if.in_byte <= next_item.in_byte;
                feed_if.in_last <= next_item.in_last;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // receiver: rotating stall mask, reloaded at random each time the phase counter wraps
    always @(posedge clk)
    begin
        if (stall_phase == 0)
            stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        else
            stall_mask = {stall_mask[0], stall_mask[15:1]};
        stall_phase = (stall_phase + 1) % 64;
        result_if.ready <= stall_mask[0];
    end

    task automatic push_item(input logic [BYTE_W-1:0] b, input logic last);
        feed_item_t item;
        item.in_byte = b;
        item.in_last = last;
        byte_queue.push_back(item);
        queued_items++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= data;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (index == CFG_PATTERN_BYTES)
            gen_pattern = data;
        else if (index == CFG_PATTERN_LENGTH)
            gen_length = data[LEN_W-1:0];
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        while ((accepted_items != queued_items || awaited_results.size() != 0)
               && waited < IDLE_BOUND)
        begin
            @(negedge clk);
            waited++;
        end
        if (accepted_items != queued_items || awaited_results.size() != 0)
        begin
            $error("stuck with %0d items unaccepted and %0d results outstanding",
                   queued_items - accepted_items, awaited_results.size());
            errors++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic pick_config();
        int i;
        case ($urandom_range(0, 9))
            0:       gen_length = LEN_W'(0);
            1:       gen_length = LEN_W'($urandom_range(9, 15));
            2:       gen_length = LEN_W'(MAX_PATTERN);
            default: gen_length = LEN_W'($urandom_range(1, 4));
        endcase
        for (i = 0; i < MAX_PATTERN; i++)
            case ($urandom_range(0, 4))
                0:       gen_pattern[8*i +: 8] = 8'h00;
                1:       gen_pattern[8*i +: 8] = 8'hFF;
                2:       gen_pattern[8*i +: 8] = 8'($urandom);
                default: gen_pattern[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 2));
            endcase
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_PATTERN_BYTES, gen_pattern);
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(gen_length));
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_UNUSED_INDEX, {$urandom, $urandom});
    endtask

    // mostly whole or cut-off pattern copies, mixed with pattern bytes and noise
    task automatic send_random_string(input bit close);
        logic [BYTE_W-1:0] text[$];
        int n;
        int plen;
        int cut;
        int i;
        plen = clamp_length(gen_length);
        n    = $urandom_range(1, 16);
        while (text.size() < n)
        begin
            case ($urandom_range(0, 5))
                0, 1, 2:
                begin
                    cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, plen) : plen;
                    for (i = 0; i < cut; i++)
                        text.push_back(gen_pattern[8*i +: 8]);
                end
                3, 4:    text.push_back(gen_pattern[8*$urandom_range(0, plen - 1) +: 8]);
                default: text.push_back(8'($urandom));
            endcase
        end
        for (i = 0; i < text.size(); i++)
            push_item(text[i], close && (i == text.size() - 1));
    endtask

    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int random_end;
        int i;
        feed_if.valid   = 1'b0;
        feed_if.in_byte = '0;
        feed_if.in_last = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.data     = '0;
        result_if.ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: single zero byte pattern
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b1);
        wait_idle();

        // two byte pattern in the middle of a string, then ending a string
        write_reg(CFG_PATTERN_BYTES, 64'h6261);
        write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(2));
        push_item(8'h78, 1'b0);
        push_item(8'h61, 1'b0);
        push_item(8'h62, 1'b0);
        push_item(8'h79, 1'b1);
        push_item(8'h61, 1'b0);
        push_item(8'h62, 1'b1);
        wait_idle();

        // length zero acts as one
        write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(0));
        push_item(8'h61, 1'b1);
        push_item(8'h62, 1'b1);
        wait_idle();

        // length above the maximum acts as the maximum
        write_reg(CFG_PATTERN_BYTES, {CFG_DATA_W{1'b1}});
        write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(15));
        for (i = 0; i < MAX_PATTERN; i++)
            push_item(8'hFF, i == MAX_PATTERN - 1);
        wait_idle();

        // shrink length and change pattern with bytes held in the window
        write_reg(CFG_PATTERN_BYTES, 64'h0807_0605_0403_0201);
        push_item(8'h01, 1'b0);
        push_item(8'h02, 1'b0);
        push_item(8'h03, 1'b0);
        push_item(8'hAA, 1'b0);
        push_item(8'h05, 1'b0);
        wait_idle();
        write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(2));
        write_reg(CFG_PATTERN_BYTES, 64'h0005);
        write_reg(CFG_UNUSED_INDEX, 64'h3);
        push_item(8'h00, 1'b1);
        wait_idle();

        random_end = queued_items + RANDOM_ITEMS;
        while (queued_items < random_end)
        begin
            pick_config();
            repeat ($urandom_range(1, 4)) send_random_string(1'b1);
            // sometimes leave a string open across the next register write
            if ($urandom_range(0, 2) == 0)
                send_random_string(1'b0);
            wait_idle();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
